FILE: src/md5_pkg.sv
// md5 engine package: state encoding, round constants, rotate amounts, message index
// no dependencies
package md5_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD2,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       wr_byte;
        logic [5:0] wr_pos;
        logic [7:0] wr_val;
        logic       clr_above;
        logic       clr_low14;
        logic       wr_len;
        logic       rnd_start;
        logic       rnd_step;
        logic       add_chain;
        logic       ld_out;
        logic       restart;
    } t_cmd;

    typedef struct packed {
        logic [5:0] pos;
        logic       rnd_last;
    } t_status;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam logic [31:0] K_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] S_TAB [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    function automatic logic [3:0] msg_index(input logic [5:0] i);
        logic [3:0] lo;
        lo = i[3:0];
        unique case (i[5:4])
            2'd0: msg_index = lo;
            2'd1: msg_index = 4'((lo * 5) + 1);
            2'd2: msg_index = 4'((lo * 3) + 5);
            default: msg_index = 4'(lo * 7);
        endcase
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] d;
        d = {v, v} << s;
        rotl = d[63:32];
    endfunction

endpackage

FILE: src/md5_datapath.sv
// md5 datapath: block store, byte count, round registers, chaining words
// depends on md5_pkg
module md5_datapath
    import md5_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    output t_status       o_status,
    output logic [127:0]  o_digest
);

    logic [31:0] r_blk [16];
    logic [31:0] r_h [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [63:0] r_total;
    logic [5:0]  r_rnd;
    logic [127:0] r_dig;

    logic [31:0] f, sum, nb;
    logic [1:0]  stg;
    logic [63:0] bits;

    assign stg  = r_rnd[5:4];
    assign bits = r_total << 3;

    always_comb begin
        unique case (stg)
            2'd0: f = r_d ^ (r_b & (r_c ^ r_d));
            2'd1: f = r_c ^ (r_d & (r_b ^ r_c));
            2'd2: f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
        sum = r_a + f + K_TAB[r_rnd] + r_blk[msg_index(r_rnd)];
        nb  = r_b + rotl(sum, S_TAB[{stg, r_rnd[1:0]}]);
    end

    always_ff @(posedge i_clk) begin
        for (int w = 0; w < 16; w++) begin
            if (i_cmd.wr_byte && i_cmd.wr_pos[5:2] == 4'(w)) begin
                unique case (i_cmd.wr_pos[1:0])
                    2'd0: r_blk[w] <= {24'd0, i_cmd.wr_val};
                    2'd1: r_blk[w] <= {16'd0, i_cmd.wr_val, r_blk[w][7:0]};
                    2'd2: r_blk[w] <= {8'd0, i_cmd.wr_val, r_blk[w][15:0]};
                    default: r_blk[w] <= {i_cmd.wr_val, r_blk[w][23:0]};
                endcase
            end else if (i_cmd.clr_above && 4'(w) > i_cmd.wr_pos[5:2]) begin
                r_blk[w] <= '0;
            end else if (i_cmd.clr_low14 && w < 14) begin
                r_blk[w] <= '0;
            end
        end
        if (i_cmd.wr_len) begin
            r_blk[14] <= bits[31:0];
            r_blk[15] <= bits[63:32];
        end
        if (i_cmd.rnd_start) begin
            r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3];
        end else if (i_cmd.rnd_step) begin
            r_a <= r_d; r_d <= r_c; r_c <= r_b; r_b <= nb;
        end
        if (i_cmd.ld_out) r_dig <= {r_h[3], r_h[2], r_h[1], r_h[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_h[0] <= IV0; r_h[1] <= IV1; r_h[2] <= IV2; r_h[3] <= IV3;
            r_total <= '0;
            r_rnd <= '0;
        end else begin
            if (i_cmd.wr_byte && !i_cmd.clr_above) r_total <= r_total + 64'd1;
            if (i_cmd.rnd_start) r_rnd <= '0;
            else if (i_cmd.rnd_step) r_rnd <= r_rnd + 6'd1;
            if (i_cmd.add_chain) begin
                r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
            end
        end
    end

    assign o_status.pos      = r_total[5:0];
    assign o_status.rnd_last = (r_rnd == 6'd63);
    assign o_digest          = r_dig;

endmodule

FILE: src/md5_control.sv
// md5 controller: sequences absorb, padding, rounds and digest hand-off
// depends on md5_pkg
module md5_control
    import md5_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_command,
    input  logic [7:0] i_byte,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_fin, n_fin;
    logic   r_two, n_two;
    logic   r_oval, n_oval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fin <= 1'b0;
            r_two <= 1'b0;
            r_oval <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fin <= n_fin;
            r_two <= n_two;
            r_oval <= n_oval;
        end
    end

    always_comb begin
        n_state = r_state;
        n_fin = r_fin;
        n_two = r_two;
        n_oval = r_oval && !i_out_ready;
        o_cmd = '0;
        o_ready = 1'b0;
        o_valid = r_oval;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                o_cmd.wr_pos = i_status.pos;
                if (i_valid) begin
                    o_cmd.wr_byte = 1'b1;
                    o_cmd.rnd_start = 1'b1;
                    if (!i_command) begin
                        o_cmd.wr_val = i_byte;
                        n_fin = 1'b0;
                        if (i_status.pos == 6'd63) n_state = ST_ROUND;
                    end else begin
                        o_cmd.wr_val = PAD_BYTE;
                        o_cmd.clr_above = 1'b1;
                        n_fin = 1'b1;
                        n_two = (i_status.pos >= 6'd56);
                        n_state = (i_status.pos >= 6'd56) ? ST_ROUND : ST_PAD2;
                    end
                end
            end
            ST_PAD2: begin
                o_cmd.wr_len = 1'b1;
                o_cmd.rnd_start = 1'b1;
                n_two = 1'b0;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.rnd_step = 1'b1;
                if (i_status.rnd_last) n_state = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.add_chain = 1'b1;
                if (!r_fin) n_state = ST_IDLE;
                else if (r_two) begin
                    o_cmd.clr_low14 = 1'b1;
                    n_state = ST_PAD2;
                end else n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_oval || i_out_ready) begin
                    o_cmd.ld_out = 1'b1;
                    o_cmd.restart = 1'b1;
                    n_oval = 1'b1;
                    n_fin = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTH
    a_out_after_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> r_fin) else $error("digest without finish");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> !o_ready) else $error("accept during rounds");
    a_round_to_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && i_status.rnd_last) |=> (r_state == ST_ADD))
        else $error("round count lost");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_out_ready) |=> o_valid) else $error("digest dropped");
`endif

endmodule

FILE: src/md5_hash_engine_unit.sv
// md5 engine top level: stream ports around controller and datapath
// depends on md5_pkg, md5_control, md5_datapath
// Bytes are taken while idle; a byte that fills a 64-byte block starts the round loop
// (one round per cycle) and chaining add. A finish compresses one padded block, or two
// when 56 or more bytes are pending; its output step waits while an earlier digest
// is still untaken; the digest then sits in an output register until it is taken. The
// digest comes as one transaction: low half in tdata bits 63:0, high half above.
module md5_hash_engine_unit
    import md5_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte
    input  logic         s_axis_tuser,   // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // digest_low, digest_high
);

    t_cmd    cmd;
    t_status status;

    md5_control u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .i_command(s_axis_tuser), .i_byte(s_axis_tdata),
        .o_ready(s_axis_tready), .o_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_status(status), .o_cmd(cmd)
    );

    md5_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_status(status), .o_digest(m_axis_tdata)
    );

endmodule

FILE: tb/tb.sv
// testbench for md5_hash_engine_unit: byte stream in, digest transactions out
// self-contained md5 predictor checks each digest; depends on md5_pkg and the rtl only
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import md5_pkg::*;

    localparam bit CMD_ABSORB = 1'b0;
    localparam bit CMD_FINISH = 1'b1;
    localparam int STALL_LIMIT = 20000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = '0;   // data_byte
    logic         s_axis_tuser = 1'b0; // command
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;        // digest_low, digest_high

    md5_hash_engine_unit dut (.*);

    always #5 i_clk = ~i_clk;

    logic [31:0]  chain_q [4];
    logic [31:0]  blk_q [16];
    logic [63:0]  byte_cnt;
    logic [127:0] digest_fifo [$];
    int           errors = 0;
    int           idle_cycles = 0;
    bit           hold_rx = 1'b0;
    bit           bursty = 1'b1;

    function automatic logic [31:0] rot32(logic [31:0] v, int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    task automatic md5_compress();
        logic [31:0] a, b, c, d, f, t, sum;
        int g, st;
        a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
        for (int i = 0; i < 64; i++) begin
            st = i / 16;
            case (st)
                0: begin f = d ^ (b & (c ^ d)); g = i; end
                1: begin f = c ^ (d & (b ^ c)); g = (5 * i + 1) % 16; end
                2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
            endcase
            sum = a + f + K_TAB[i] + blk_q[g];
            t = d; d = c; c = b;
            b = b + rot32(sum, S_TAB[st * 4 + i % 4]);
            a = t;
        end
        chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d;
    endtask

    task automatic md5_restart();
        chain_q = '{IV0, IV1, IV2, IV3};
        byte_cnt = '0;
    endtask

    task automatic put_block_byte(int pos, logic [7:0] v);
        int sh;
        sh = (pos % 4) * 8;
        if (sh == 0) blk_q[pos / 4] = {24'd0, v};
        else blk_q[pos / 4] = (blk_q[pos / 4] & ((32'd1 << sh) - 1)) | (32'(v) << sh);
    endtask

    task automatic predict_md5(bit cmd, logic [7:0] data);
        int pos;
        logic [63:0] bits;
        pos = int'(byte_cnt[5:0]);
        if (cmd == CMD_ABSORB) begin
            put_block_byte(pos, data);
            byte_cnt++;
            if (pos == 63) md5_compress();
        end else begin
            bits = byte_cnt << 3;
            put_block_byte(pos, PAD_BYTE);
            for (int w = pos / 4 + 1; w < 16; w++) blk_q[w] = '0;
            if (pos >= 56) begin
                md5_compress();
                for (int w = 0; w < 14; w++) blk_q[w] = '0;
            end
            blk_q[14] = bits[31:0];
            blk_q[15] = bits[63:32];
            md5_compress();
            digest_fifo.push_back({chain_q[3], chain_q[2], chain_q[1], chain_q[0]});
            md5_restart();
        end
    endtask

    task automatic send_item(bit cmd, logic [7:0] data);
        if (bursty && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_md5(cmd, data);
    endtask

    task automatic send_message(int len, bit fixed, logic [7:0] val);
        for (int i = 0; i < len; i++)
            send_item(CMD_ABSORB, fixed ? val : 8'($urandom));
        send_item(CMD_FINISH, 8'($urandom));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (digest_fifo.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_item(CMD_FINISH, 8'hff);
        send_message(1, 1'b1, 8'h00);
        send_message(3, 1'b1, 8'hff);
        send_message(55, 1'b0, 8'h00);
        send_message(56, 1'b0, 8'h00);
        wait_drained();
    endtask

    task automatic test_block_edges();
        send_message(63, 1'b0, 8'h00);
        send_message(64, 1'b1, 8'h5a);
        send_message(65, 1'b0, 8'h00);
        send_message(120, 1'b1, 8'ha5);
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_rx = 1'b1;
        bursty = 1'b0;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            begin
                send_message(2, 1'b0, 8'h00);
                send_message(5, 1'b0, 8'h00);
                send_message(1, 1'b0, 8'h00);
            end
        join
        bursty = 1'b1;
        wait_drained();
    endtask

    task automatic test_random();
        int len;
        for (int n = 0; n < 31; n++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 20);
            send_message(len, 1'b0, 8'h00);
            if ($urandom_range(0, 7) == 0) wait_drained();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_rx) m_axis_tready <= 1'b0;
        else if (bursty) m_axis_tready <= ($urandom_range(0, 3) != 0);
        else m_axis_tready <= 1'b1;
    end

    always @(posedge i_clk) begin
        logic [127:0] exp_d;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (digest_fifo.size() == 0) begin
                $error("digest transaction with none expected: %h", m_axis_tdata);
                errors++;
            end else begin
                exp_d = digest_fifo.pop_front();
                if (m_axis_tdata[63:0] !== exp_d[63:0]) begin
                    $error("digest_low expected %h actual %h", exp_d[63:0], m_axis_tdata[63:0]);
                    errors++;
                end
                if (m_axis_tdata[127:64] !== exp_d[127:64]) begin
                    $error("digest_high expected %h actual %h",
                           exp_d[127:64], m_axis_tdata[127:64]);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        md5_restart();
        foreach (blk_q[i]) blk_q[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_block_edges();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && digest_fifo.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
